// File: rtl/core/lnfp_pkg.sv
// lnfp_pkg: shared types and constants for the login name field parser
// used by lnfp_front, lnfp_back and login_name_field_parser; no dependencies
`timescale 1ns / 1ps

package lnfp_pkg;

    // default field limits, counted with room for a terminator
    localparam int NAME_MAX_LEN_DEF  = 64;
    localparam int REALM_MAX_LEN_DEF = 64;

    // length counter covers limits up to 127
    localparam int LEN_W = 7;

    // decoupling queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INST_WANTED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WANTED = 1'd1;

    // special characters
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        FM_NAME = 2'd0,
        FM_INST = 2'd1,
        FM_CELL = 2'd2
    } t_field;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_QUOTE = 2'd1,
        ESC_OCT1  = 2'd2,
        ESC_OCT2  = 2'd3
    } t_esc;

    // one classified input word as it sits in the queue
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
        logic       is_bsl;
        logic       is_dot;
        logic       is_at;
        logic       is_oct;
    } t_q_word;

    // queue status toward the back end
    typedef struct packed {
        logic    valid;
        t_q_word word;
    } t_q_head;

endpackage

// File: rtl/core/lnfp_front.sv
// lnfp_front: accepts input words, classifies them, holds them in a short queue
// depends on lnfp_pkg
`timescale 1ns / 1ps

module lnfp_front
    import lnfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_last_char,
    output t_q_head    o_head,
    input  logic       i_pop
);

    t_q_word              r_q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;
    logic                 push;
    logic                 pop;
    t_q_word              in_word;

    always_comb begin
        in_word.char_in   = i_char_in;
        in_word.last_char = i_last_char;
        in_word.is_bsl    = (i_char_in == CH_BSL);
        in_word.is_dot    = (i_char_in == CH_DOT);
        in_word.is_at     = (i_char_in == CH_AT);
        in_word.is_oct    = (i_char_in >= CH_ZERO) && (i_char_in <= CH_SEVEN);
    end

    assign o_in_stall = (r_count == Q_CNT_W'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_q_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_mem[r_wr_ptr] <= in_word;
        end
    end

endmodule

// File: rtl/core/lnfp_back.sv
// lnfp_back: escape decoding, field tracking and the registered result word
// depends on lnfp_pkg; fed by lnfp_front
`timescale 1ns / 1ps

module lnfp_back
    import lnfp_pkg::*;
#(
    parameter int NAME_MAX_LEN  = NAME_MAX_LEN_DEF,
    parameter int REALM_MAX_LEN = REALM_MAX_LEN_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_head    i_head,
    output logic       o_pop,
    input  logic       i_inst_wanted,
    input  logic       i_cell_wanted,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_char_valid,
    output logic [1:0] o_field_tag,
    output logic [7:0] o_char_value,
    output logic       o_string_done,
    output logic       o_parse_status
);

    localparam logic [LEN_W-1:0] NAME_LIM  = LEN_W'(NAME_MAX_LEN - 1);
    localparam logic [LEN_W-1:0] REALM_LIM = LEN_W'(REALM_MAX_LEN - 1);

    t_field             r_mode, n_mode;
    t_esc               r_esc, n_esc;
    logic [7:0]         r_acc, n_acc;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_err, n_err;

    logic               r_out_valid;
    logic               r_char_valid, r_string_done, r_parse_status;
    logic [1:0]         r_field_tag;
    logic [7:0]         r_char_value;

    logic               take;
    logic               quiet;
    logic               sep_ok;
    logic               emit;
    logic [7:0]         c;
    logic [7:0]         acc_step;
    logic               res_valid;
    logic [1:0]         res_tag;
    logic [7:0]         res_value;
    t_q_word            w;

    assign w     = i_head.word;
    assign o_pop = i_head.valid && (!r_out_valid || !i_out_stall);

    // next octal accumulator value, modulo 256
    assign acc_step = {r_acc[4:0], 3'b000} + w.char_in - CH_ZERO;

    always_comb begin
        n_mode    = r_mode;
        n_esc     = r_esc;
        n_acc     = r_acc;
        n_len     = r_len;
        n_err     = r_err;
        take      = 1'b0;
        quiet     = 1'b0;
        sep_ok    = 1'b0;
        emit      = 1'b0;
        c         = 8'h00;
        res_valid = 1'b0;
        res_tag   = 2'd0;
        res_value = 8'h00;

        if (!r_err) begin
            // escape decoding
            case (r_esc)
                ESC_NONE: begin
                    if (w.is_bsl) begin
                        if (w.last_char) begin
                            take  = 1'b1;  // trailing backslash counts as a zero byte
                            quiet = 1'b1;  // but nothing is emitted for it
                        end else begin
                            n_esc = ESC_QUOTE;
                        end
                    end else begin
                        c      = w.char_in;
                        take   = 1'b1;
                        sep_ok = 1'b1;
                    end
                end
                ESC_QUOTE: begin
                    if (w.is_oct) begin
                        n_acc = {5'b00000, w.char_in[2:0]};
                        n_esc = ESC_OCT1;
                        if (w.last_char) begin
                            n_err = 1'b1;
                        end
                    end else begin
                        n_esc = ESC_NONE;
                        c     = w.char_in;
                        take  = 1'b1;
                    end
                end
                ESC_OCT1: begin
                    n_acc = acc_step;
                    n_esc = ESC_OCT2;
                    if (w.last_char) begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    n_acc = acc_step;
                    n_esc = ESC_NONE;
                    c     = acc_step;
                    take  = 1'b1;
                end
            endcase

            // field tracking
            if (take) begin
                case (r_mode)
                    FM_NAME: begin
                        if (sep_ok && w.is_at) begin
                            n_mode = FM_CELL;
                            n_len  = '0;
                        end else if (sep_ok && w.is_dot && i_inst_wanted) begin
                            n_mode = FM_INST;
                            n_len  = '0;
                        end else if (r_len >= NAME_LIM) begin
                            n_err = 1'b1;
                        end else begin
                            n_len = r_len + 1'b1;
                            emit  = 1'b1;
                        end
                    end
                    FM_INST: begin
                        if (!i_inst_wanted) begin
                            n_err = 1'b1;
                        end else if (sep_ok && w.is_at) begin
                            n_mode = FM_CELL;
                            n_len  = '0;
                        end else if (r_len >= NAME_LIM) begin
                            n_err = 1'b1;
                        end else begin
                            n_len = r_len + 1'b1;
                            emit  = 1'b1;
                        end
                    end
                    default: begin
                        if (!i_cell_wanted) begin
                            n_err = 1'b1;
                        end else if (r_len >= REALM_LIM) begin
                            n_err = 1'b1;
                        end else begin
                            n_len = r_len + 1'b1;
                            emit  = 1'b1;
                        end
                    end
                endcase
            end

            if (emit && !quiet && !n_err) begin
                res_valid = 1'b1;
                res_tag   = n_mode;
                res_value = c;
                if (n_mode == FM_CELL && c >= CH_LOW_A && c <= CH_LOW_Z) begin
                    res_value = c - CASE_OFS;
                end
            end

            // string ending inside an unwanted field
            if (w.last_char && !n_err) begin
                if ((n_mode == FM_INST && !i_inst_wanted) ||
                    (n_mode == FM_CELL && !i_cell_wanted)) begin
                    n_err = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= FM_NAME;
            r_esc       <= ESC_NONE;
            r_acc       <= '0;
            r_len       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (w.last_char) begin
                    r_mode <= FM_NAME;
                    r_esc  <= ESC_NONE;
                    r_acc  <= '0;
                    r_len  <= '0;
                    r_err  <= 1'b0;
                end else begin
                    r_mode <= n_mode;
                    r_esc  <= n_esc;
                    r_acc  <= n_acc;
                    r_len  <= n_len;
                    r_err  <= n_err;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_char_valid   <= res_valid;
            r_field_tag    <= res_tag;
            r_char_value   <= res_value;
            r_string_done  <= w.last_char;
            r_parse_status <= n_err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_char_valid   = r_char_valid;
    assign o_field_tag    = r_field_tag;
    assign o_char_value   = r_char_value;
    assign o_string_done  = r_string_done;
    assign o_parse_status = r_parse_status;

endmodule

// File: rtl/core/login_name_field_parser.sv
// login_name_field_parser: top level of the login name field parser
// depends on lnfp_pkg, lnfp_front and lnfp_back
`timescale 1ns / 1ps

// usage
//   input channel: one raw byte of a login string per word (i_char_in), with
//   i_last_char high on the final byte; taken when i_in_valid is high and
//   o_in_stall is low
//   output channel: exactly one result word per input word, in order; taken
//   when o_out_valid is high and i_out_stall is low
//   config channel: i_cfg_index 0 is inst_wanted, 1 is cell_wanted; o_cfg_ready
//   is always high, write only while no string is in flight
//   result path: the byte is written to the queue at the accepting edge, then
//   it is decoded from the queue head into the result register in the back
//   end, which raises o_out_valid; a stalled output delays the second step
//   throughput: one byte per cycle while the output is not stalled; the
//   escape and field state is updated once per byte in the back end
//   stall: a stalled output holds its word; the two-entry queue then fills and
//   o_in_stall rises, no word is dropped
//   reset: synchronous; i_rst_n low clears the queue, the parse state and the
//   output valid, and sets both config bits to 1
module login_name_field_parser
    import lnfp_pkg::*;
#(
    parameter int NAME_MAX_LEN  = NAME_MAX_LEN_DEF,
    parameter int REALM_MAX_LEN = REALM_MAX_LEN_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_char_in,
    input  logic                 i_last_char,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_char_valid,
    output logic [1:0]           o_field_tag,
    output logic [7:0]           o_char_value,
    output logic                 o_string_done,
    output logic                 o_parse_status,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data
);

    logic    r_inst_wanted;
    logic    r_cell_wanted;
    t_q_head q_head;
    logic    q_pop;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inst_wanted <= 1'b1;
            r_cell_wanted <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_INST_WANTED: r_inst_wanted <= i_cfg_data;
                CFG_CELL_WANTED: r_cell_wanted <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front end: classify each byte and queue it
    lnfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_in   (i_char_in),
        .i_last_char (i_last_char),
        .o_head      (q_head),
        .i_pop       (q_pop)
    );

    // back end: escapes, field split, length checks, result register
    lnfp_back #(
        .NAME_MAX_LEN  (NAME_MAX_LEN),
        .REALM_MAX_LEN (REALM_MAX_LEN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .o_pop          (q_pop),
        .i_inst_wanted  (r_inst_wanted),
        .i_cell_wanted  (r_cell_wanted),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_char_valid   (o_char_valid),
        .o_field_tag    (o_field_tag),
        .o_char_value   (o_char_value),
        .o_string_done  (o_string_done),
        .o_parse_status (o_parse_status)
    );

endmodule
